/* src/mandelbrot_escape_time_core_assert.svh */
// Assertion macros used by the checker file of the escape-time core.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH

// Same-cycle implication.
`define MET_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MET_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

/* src/met_pkg.sv */
// Shared constants, register indexes and control types of the escape-time core.
package met_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 28;

  localparam int PIX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int STEP_W     = 31;
  localparam int CENTER_W   = 32;
  localparam int ITER_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // (2*pixel - size) and its product with a step
  localparam int DIFF_W = SIZE_W + 1;
  localparam int MAP_W  = DIFF_W + STEP_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 3'd6;

  localparam logic signed [CENTER_W-1:0] CENTER_X_RST   = -32'sd134217728;
  localparam logic signed [CENTER_W-1:0] CENTER_Y_RST   = 32'sd0;
  localparam logic [STEP_W-1:0]          STEP_X_RST     = 31'd1006632;
  localparam logic [STEP_W-1:0]          STEP_Y_RST     = 31'd1342177;
  localparam logic [SIZE_W-1:0]          WIDTH_RST      = 13'd800;
  localparam logic [SIZE_W-1:0]          HEIGHT_RST     = 13'd600;
  localparam logic [ITER_W-1:0]          ITER_LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic load_pix;  // capture the pixel word
    logic map_x;     // multiply the column offset
    logic map_y;     // finish cx, multiply the row offset
    logic map_c;     // finish cy, clear z and count
    logic mul;       // register the three products
    logic upd;       // advance z and the count
    logic load_out;  // copy the result to the output register
  } met_cmd_t;

  typedef struct packed {
    logic limit;     // count reached iter_limit
    logic escape;    // |z|^2 above four
  } met_stat_t;

endpackage

/* src/met_ctrl.sv */
// Sequencer of the escape-time core: mapping steps, iteration loop, output handshake.
module met_ctrl
  import met_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  input  met_stat_t stat,
  output met_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAPX = 3'd1;
  localparam logic [2:0] ST_MAPY = 3'd2;
  localparam logic [2:0] ST_MAPC = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_pix = 1'b1;
          state_next   = ST_MAPX;
        end
      end
      ST_MAPX: begin
        cmd.map_x  = 1'b1;
        state_next = ST_MAPY;
      end
      ST_MAPY: begin
        cmd.map_y  = 1'b1;
        state_next = ST_MAPC;
      end
      ST_MAPC: begin
        cmd.map_c  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (stat.limit) begin
          state_next = ST_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (stat.escape) begin
          state_next = ST_DONE;
        end else begin
          cmd.upd    = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* src/met_dp.sv */
// Datapath of the escape-time core: register file, pixel mapping, z iteration, result register.
module met_dp
  import met_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [2*PIX_W-1:0]    pix_word,
  input  met_cmd_t              cmd,
  output met_stat_t             stat,
  output logic [ITER_W-1:0]     out_iter,
  output logic                  out_in_set
);

  localparam int C  = COORD_BITS;
  localparam int EW = ((C > MAP_W) ? C : MAP_W) + 2;

  localparam logic signed [EW-1:0]  CMAX_E = {{(EW - C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [EW-1:0]  CMIN_E = ~CMAX_E;
  localparam logic signed [2*C-1:0] CMAX_P = {{(C + 1){1'b0}}, {(C - 1){1'b1}}};
  localparam logic signed [2*C-1:0] CMIN_P = ~CMAX_P;
  localparam logic signed [C-1:0]   CMAX_C = {1'b0, {(C - 1){1'b1}}};
  localparam logic signed [C-1:0]   CMIN_C = ~CMAX_C;
  localparam logic [C:0]            FOUR   = {{C{1'b0}}, 1'b1} << (FRAC_BITS + 2);

  function automatic logic signed [C-1:0] clamp_e(input logic signed [EW-1:0] v);
    if (v > CMAX_E) begin
      return CMAX_C;
    end else if (v < CMIN_E) begin
      return CMIN_C;
    end
    return v[C-1:0];
  endfunction

  function automatic logic signed [C-1:0] clamp_p(input logic signed [2*C-1:0] v);
    if (v > CMAX_P) begin
      return CMAX_C;
    end else if (v < CMIN_P) begin
      return CMIN_C;
    end
    return v[C-1:0];
  endfunction

  // sum of two in-range values carries one extra bit
  function automatic logic signed [C-1:0] sat_add(input logic signed [C-1:0] a,
                                                  input logic signed [C-1:0] b);
    logic signed [C:0] s;
    s = {a[C-1], a} + {b[C-1], b};
    if (s[C] != s[C-1]) begin
      return s[C] ? CMIN_C : CMAX_C;
    end
    return s[C-1:0];
  endfunction

  // configuration registers
  logic signed [CENTER_W-1:0] center_x;
  logic signed [CENTER_W-1:0] center_y;
  logic [STEP_W-1:0]          step_x;
  logic [STEP_W-1:0]          step_y;
  logic [SIZE_W-1:0]          image_width;
  logic [SIZE_W-1:0]          image_height;
  logic [ITER_W-1:0]          iter_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CENTER_X_RST;
      center_y     <= CENTER_Y_RST;
      step_x       <= STEP_X_RST;
      step_y       <= STEP_Y_RST;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      iter_limit   <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[CENTER_W-1:0];
        REG_STEP_X:       step_x       <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:       step_y       <= cfg_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[SIZE_W-1:0];
        REG_ITER_LIMIT:   iter_limit   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel mapping: one shared multiplier, x axis first
  logic [PIX_W-1:0]           pix_x;
  logic [PIX_W-1:0]           pix_y;
  logic [PIX_W-1:0]           map_pix;
  logic [SIZE_W-1:0]          map_size;
  logic [STEP_W-1:0]          map_step;
  logic signed [DIFF_W-1:0]   map_diff;
  logic signed [MAP_W-1:0]    map_prod;
  logic signed [MAP_W-1:0]    prod_m;
  logic signed [MAP_W-1:0]    map_off;
  logic signed [CENTER_W-1:0] map_center;
  logic signed [C-1:0]        map_c;

  assign map_pix  = cmd.map_y ? pix_y : pix_x;
  assign map_size = cmd.map_y ? image_height : image_width;
  assign map_step = cmd.map_y ? step_y : step_x;
  assign map_diff = $signed({1'b0, map_pix, 1'b0}) - $signed({1'b0, map_size});
  assign map_prod = map_diff * $signed({1'b0, map_step});

  // floor of half the product
  assign map_off    = prod_m >>> 1;
  assign map_center = cmd.map_c ? center_y : center_x;
  assign map_c = sat_add(
      clamp_e({{(EW - CENTER_W){map_center[CENTER_W-1]}}, map_center}),
      clamp_e({{(EW - MAP_W){map_off[MAP_W-1]}}, map_off}));

  // iteration
  logic signed [C-1:0]   cx;
  logic signed [C-1:0]   cy;
  logic signed [C-1:0]   zx;
  logic signed [C-1:0]   zy;
  logic [ITER_W-1:0]     iter;
  logic signed [2*C-1:0] pxx;
  logic signed [2*C-1:0] pyy;
  logic signed [2*C-1:0] pxy;
  logic signed [C-1:0]   sq_x;
  logic signed [C-1:0]   sq_y;
  logic signed [C-1:0]   twice_xy;
  logic [C:0]            mag;
  logic signed [C-1:0]   zx_next;
  logic signed [C-1:0]   zy_next;

  assign sq_x     = clamp_p(pxx >>> FRAC_BITS);
  assign sq_y     = clamp_p(pyy >>> FRAC_BITS);
  assign twice_xy = clamp_p(pxy >>> (FRAC_BITS - 1));
  assign mag      = {1'b0, sq_x} + {1'b0, sq_y};
  assign zx_next  = sat_add(sat_add(sq_x, -sq_y), cx);
  assign zy_next  = sat_add(twice_xy, cy);

  assign stat.escape = (mag > FOUR);
  assign stat.limit  = !(iter < iter_limit);

  always_ff @(posedge clk) begin
    if (cmd.load_pix) begin
      pix_x <= pix_word[PIX_W-1:0];
      pix_y <= pix_word[2*PIX_W-1:PIX_W];
    end
    if (cmd.map_x || cmd.map_y) begin
      prod_m <= map_prod;
    end
    if (cmd.map_y) begin
      cx <= map_c;
    end
    if (cmd.map_c) begin
      cy   <= map_c;
      zx   <= '0;
      zy   <= '0;
      iter <= '0;
    end
    if (cmd.mul) begin
      pxx <= zx * zx;
      pyy <= zy * zy;
      pxy <= zx * zy;
    end
    if (cmd.upd) begin
      zx   <= zx_next;
      zy   <= zy_next;
      iter <= iter + 1'b1;
    end
    if (cmd.load_out) begin
      out_iter   <= iter;
      out_in_set <= (iter == iter_limit);
    end
  end

endmodule

/* src/mandelbrot_escape_time_core.sv */
// Top level of the Mandelbrot escape-time pixel engine.
// Usage:
//   Write the view registers on the cfg channel (cfg_index selects, cfg_data carries
//   the value) while no pixel is in flight; cfg_ready is always high.
//   Send one pixel word on s_* (pixel_x, pixel_y); one result word comes back on
//   m_* with the iteration count in m_tdata and the in-set flag in m_tuser.
// Timing:
//   One pixel at a time; s_tready is high only while the engine is idle.
//   Mapping to c runs through the MAPX, MAPY and MAPC steps on the shared
//   mapping multiplier, then each iteration has a product step and an update
//   step (product registers, then saturate and update).
//   The z*z loop sets the rate; points in the set run it up to iter_limit.
// Reset: returns to idle, drops m_tvalid and reloads the default view.
// Stall: a result waits in the output register; a finished pixel holds until
//   that register is free, and no new pixel is taken meanwhile.
module mandelbrot_escape_time_core
  import met_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2*PIX_W-1:0]    s_tdata,   // pixel_x [11:0], pixel_y [23:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [ITER_W-1:0]     m_tdata,   // iterations [15:0]
  output logic                  m_tuser    // in_set [0]
);

  met_cmd_t  cmd;
  met_stat_t stat;

  assign cfg_ready = 1'b1;

  met_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  met_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_word   (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_iter   (m_tdata),
    .out_in_set (m_tuser)
  );

endmodule

/* src/met_checker.sv */
// Port-level checker of the escape-time core and its bind.
`include "mandelbrot_escape_time_core_assert.svh"

module met_checker
  import met_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [ITER_W-1:0]     m_tdata,
  input logic                  m_tuser
);

  logic [ITER_W-1:0] limit_shadow;

  // track the iteration limit as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_shadow <= ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready && (cfg_index == REG_ITER_LIMIT)) begin
      limit_shadow <= cfg_data[ITER_W-1:0];
    end
  end

  `MET_ASSERT_IMP(a_flag_matches_limit, clk, rst, m_tvalid, m_tuser == (m_tdata == limit_shadow), "in_set disagrees with the count and the limit")
  `MET_ASSERT_IMP(a_count_in_range, clk, rst, m_tvalid, m_tdata <= limit_shadow, "iteration count above the limit")
  `MET_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input taken again right after a word")
  `MET_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")
  `MET_ASSERT_NXT(a_reset_clears_out, clk, 1'b0, rst, !m_tvalid, "result word valid after reset")

endmodule

bind mandelbrot_escape_time_core met_checker u_met_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);
